>>> sv/gdt_pkg.sv
package gdt_pkg;

    // input item fields
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 7;
    localparam int DIST_W = 7;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [CFG_W-1:0]  DIM_RESET = 7'd64;
    localparam logic [DIST_W-1:0] DIST_SAT  = 7'd126;
    localparam logic [DIST_W-1:0] DIST_NONE = 7'd127;

endpackage

>>> sv/grid_distance_transform_top.sv
// grid distance transform
// input stream: each transfer is a load (write one cell bit) or a read (fetch one
// cell distance). a load with tlast high starts the breadth-first transform.
// output stream: one transfer per read, none per load.
// configuration: i_cfg_we with i_cfg_idx 0 sets the row count, 1 the column count;
// write only while the block is idle.
// timing: a read passes through the S_RD state and then the output register. the
// transform first sweeps the configured area, one cell a cycle, then steps through
// S_QRD, S_QWAIT, S_DWAIT and S_NB for every queued cell, set by the single read and
// write port of the distance memory (one neighbour probe a cycle).
// reads during the transform wait (o_s_tready low); reads of an unfinished grid
// report not_ready.
// reset: rows and columns go to 64, the grid counts as not transformed; the
// distance memory keeps no reset value and every cell must be loaded first.
// a stalled output holds its result; the input is taken only while the output
// register is empty or being emptied.
module grid_distance_transform_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [0] opcode, [6:1] cell_row, [12:7] cell_col, [13] cell_bit, [15:14] zero
    input  logic [gdt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [6:0] distance, [7] no_source, [8] not_ready, [15:9] zero
    output logic [gdt_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [gdt_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int QPW   = $clog2(CELLS + 1);
    localparam int DW    = $clog2(MAX_ROWS + MAX_COLS);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_SCAN, S_SCAN_END, S_QRD, S_QWAIT, S_DWAIT, S_NB
    } t_state;

    function automatic logic [gdt_pkg::CFG_W-1:0] clamp_dim(
        input logic [gdt_pkg::CFG_W-1:0] v, input int mx);
        logic [gdt_pkg::CFG_W-1:0] res;
        res = v;
        if (v == '0) res = gdt_pkg::CFG_W'(1);
        else if (32'(v) > mx) res = gdt_pkg::CFG_W'(mx);
        return res;
    endfunction

    t_state r_state;
    logic [gdt_pkg::CFG_W-1:0] r_rows, r_cols;
    logic r_done, r_seen;
    logic [QPW-1:0] r_head, r_tail;
    logic [RW-1:0] r_sr;
    logic [CW-1:0] r_sc;
    logic r_pv;
    logic [AW-1:0] r_pa, r_cur;
    logic [DW-1:0] r_nd;
    logic [2:0] r_nk;
    logic [gdt_pkg::ROW_W-1:0] r_rd_row;
    logic [gdt_pkg::COL_W-1:0] r_rd_col;
    logic r_ovalid, r_onosrc, r_onr;
    logic [gdt_pkg::DIST_W-1:0] r_odist;

    // memories
    logic [DW-1:0] dist_mem [DEPTH];
    logic [AW-1:0] queue_mem [DEPTH];
    logic [DW-1:0] r_st_q;
    logic [AW-1:0] r_q_q;
    logic st_we, q_we;
    logic [AW-1:0] st_wa, st_ra, q_wd;
    logic [DW-1:0] st_wd;

    // input fields
    logic in_op, in_bit, in_range, s_xfer;
    logic [gdt_pkg::ROW_W-1:0] in_row;
    logic [gdt_pkg::COL_W-1:0] in_col;
    logic [AW-1:0] in_addr;
    logic [gdt_pkg::CFG_W-1:0] rows_c, cols_c;
    logic [RW-1:0] cur_r;
    logic [CW-1:0] cur_c;
    logic nb_valid, relax_hit, scan_last;
    logic [AW-1:0] nb_addr;

    assign in_op    = i_s_tdata[0];
    assign in_row   = i_s_tdata[6:1];
    assign in_col   = i_s_tdata[12:7];
    assign in_bit   = i_s_tdata[13];
    assign in_range = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
    assign in_addr  = {RW'(in_row), CW'(in_col)};
    assign o_s_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_tready);
    assign s_xfer   = i_s_tvalid && o_s_tready;

    assign rows_c = clamp_dim(r_rows, MAX_ROWS);
    assign cols_c = clamp_dim(r_cols, MAX_COLS);
    assign cur_r  = r_cur[AW-1:CW];
    assign cur_c  = r_cur[CW-1:0];
    assign scan_last = (32'(r_sr) + 1 == 32'(rows_c)) && (32'(r_sc) + 1 == 32'(cols_c));
    assign relax_hit = r_pv && (r_st_q > r_nd);

    // neighbour order: up, down, left, right
    always_comb begin
        nb_valid = 1'b0;
        nb_addr  = r_cur;
        case (r_nk)
            3'd0: begin
                nb_valid = (cur_r != '0);
                nb_addr  = {cur_r - RW'(1), cur_c};
            end
            3'd1: begin
                nb_valid = (32'(cur_r) + 1 < 32'(rows_c));
                nb_addr  = {cur_r + RW'(1), cur_c};
            end
            3'd2: begin
                nb_valid = (cur_c != '0);
                nb_addr  = {cur_r, cur_c - CW'(1)};
            end
            3'd3: begin
                nb_valid = (32'(cur_c) + 1 < 32'(cols_c));
                nb_addr  = {cur_r, cur_c + CW'(1)};
            end
            default: begin
                nb_valid = 1'b0;
                nb_addr  = r_cur;
            end
        endcase
    end

    always_comb begin
        st_we = 1'b0;
        st_wa = in_addr;
        st_wd = in_bit ? '1 : '0;
        st_ra = '0;
        q_we  = 1'b0;
        q_wd  = r_pa;
        unique case (r_state)
            S_IDLE: begin
                st_ra = in_addr;
                st_we = s_xfer && (in_op == gdt_pkg::OP_LOAD) && in_range;
            end
            S_SCAN: begin
                st_ra = {r_sr, r_sc};
                q_we  = r_pv && (r_st_q == '0);
            end
            S_SCAN_END: q_we = r_pv && (r_st_q == '0);
            S_QWAIT:    st_ra = r_q_q;
            S_NB: begin
                st_ra = nb_addr;
                st_we = relax_hit;
                st_wa = r_pa;
                st_wd = r_nd;
                q_we  = relax_hit && (32'(r_tail) < CELLS);
            end
            default: st_ra = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) dist_mem[st_wa] <= st_wd;
        r_st_q <= dist_mem[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) queue_mem[AW'(r_tail)] <= q_wd;
        r_q_q <= queue_mem[AW'(r_head)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rows   <= gdt_pkg::DIM_RESET;
            r_cols   <= gdt_pkg::DIM_RESET;
            r_done   <= 1'b0;
            r_seen   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_pv     <= 1'b0;
            r_nk     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == gdt_pkg::REG_ROWS) r_rows <= i_cfg_data;
                else r_cols <= i_cfg_data;
            end
            if (r_ovalid && i_m_tready) r_ovalid <= 1'b0;
            if (q_we) r_tail <= r_tail + QPW'(1);

            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        if (in_op == gdt_pkg::OP_LOAD) begin
                            r_done <= 1'b0;
                            if (i_s_tlast) begin
                                r_state <= S_SCAN;
                                r_sr    <= '0;
                                r_sc    <= '0;
                                r_head  <= '0;
                                r_tail  <= '0;
                                r_seen  <= 1'b0;
                                r_pv    <= 1'b0;
                            end
                        end else begin
                            r_rd_row <= in_row;
                            r_rd_col <= in_col;
                            r_state  <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_ovalid <= 1'b1;
                    r_odist  <= '0;
                    r_onosrc <= 1'b0;
                    r_onr    <= 1'b0;
                    if (!r_done) begin
                        r_onr <= 1'b1;
                    end else if (!r_seen) begin
                        r_odist  <= gdt_pkg::DIST_NONE;
                        r_onosrc <= 1'b1;
                    end else if ((32'(r_rd_row) < 32'(rows_c))
                                 && (32'(r_rd_col) < 32'(cols_c))) begin
                        r_odist <= (32'(r_st_q) > 32'(gdt_pkg::DIST_SAT))
                                   ? gdt_pkg::DIST_SAT : gdt_pkg::DIST_W'(r_st_q);
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (q_we) r_seen <= 1'b1;
                    r_pv <= 1'b1;
                    r_pa <= {r_sr, r_sc};
                    if (scan_last) begin
                        r_state <= S_SCAN_END;
                    end else if (32'(r_sc) + 1 == 32'(cols_c)) begin
                        r_sc <= '0;
                        r_sr <= r_sr + RW'(1);
                    end else begin
                        r_sc <= r_sc + CW'(1);
                    end
                end
                S_SCAN_END: begin
                    if (q_we) r_seen <= 1'b1;
                    r_pv    <= 1'b0;
                    r_state <= S_QRD;
                end
                S_QRD: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + QPW'(1);
                        r_state <= S_QWAIT;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_QWAIT: begin
                    r_cur   <= r_q_q;
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    r_nd    <= r_st_q + DW'(1);
                    r_nk    <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    if (r_nk != 3'd4) begin
                        r_pv <= nb_valid;
                        r_pa <= nb_addr;
                        r_nk <= r_nk + 3'd1;
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= S_QRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'b0, r_onr, r_onosrc, r_odist};

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("queue head passed tail");

    a_tail_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tail) <= CELLS) else $error("queue tail beyond capacity");

    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (in_op == gdt_pkg::OP_READ) |=> r_state == S_RD && !r_ovalid)
        else $error("read result slot not free");

    a_no_write_in_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> !st_we && !q_we) else $error("memory write during read");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> r_state == S_IDLE && r_head == r_tail)
        else $error("transform ended with queue not empty");

endmodule
